// ===== rtl/shifting_indexed_array_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shifting indexed array core
// Each macro checks on the rising edge of clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHIFTING_INDEXED_ARRAY_CORE_ASSERT_SVH
`define SHIFTING_INDEXED_ARRAY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg
// Shared widths, codes and types of the shifting indexed array core.
// ----------------------------------------------------------------------------
package sia_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int OP_W     = 3;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FPOS_W   = 6;
	localparam int ECNT_W   = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_WRITE,
		CMD_ROTATE
	} cell_cmd_t;

	typedef enum logic {
		CS_IDLE,
		CS_SWEEP
	} ctrl_state_t;

	typedef struct packed {
		cell_cmd_t                 cmd;
		logic signed [WORD_W-1:0]  word;
	} cell_ctrl_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic                      found;
		logic [FPOS_W-1:0]         found_position;
		logic signed [WORD_W-1:0]  read_word;
		logic [ECNT_W-1:0]         entry_count;
	} rsp_t;

endpackage

// ===== rtl/sia_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_req_if / sia_rsp_if
// Valid/ready channels for requests into and results out of the array core.
// ----------------------------------------------------------------------------
interface sia_req_if;
	logic                              valid;
	logic                              ready;
	logic [sia_pkg::OP_W-1:0]          operation;
	logic [sia_pkg::POS_W-1:0]         position;
	logic signed [sia_pkg::WORD_W-1:0] data_word;

	modport source (output valid, output operation, output position, output data_word,
		input ready);
	modport sink (input valid, input operation, input position, input data_word,
		output ready);
endinterface

interface sia_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [sia_pkg::STATUS_W-1:0]        status;
	logic                                found;
	logic [sia_pkg::FPOS_W-1:0]          found_position;
	logic signed [sia_pkg::WORD_W-1:0]   read_word;
	logic [sia_pkg::ECNT_W-1:0]          entry_count;

	modport source (output valid, output status, output found, output found_position,
		output read_word, output entry_count, input ready);
	modport sink (input valid, input status, input found, input found_position,
		input read_word, input entry_count, output ready);
endinterface

// ===== rtl/sia_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_cell
// One array slot: holds, loads, or takes the word of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module sia_cell #(
	parameter int CAPACITY = sia_pkg::CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  logic                                  clk,
	input  sia_pkg::cell_ctrl_t                   ctrl,
	input  logic [$clog2(CAPACITY)-1:0]           pos,
	input  logic [$clog2(CAPACITY+1)-1:0]         count,
	input  logic signed [sia_pkg::WORD_W-1:0]     prev_word,
	input  logic signed [sia_pkg::WORD_W-1:0]     next_word,
	output logic signed [sia_pkg::WORD_W-1:0]     word
);
	import sia_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

	logic [CW-1:0]             pos_x;
	logic signed [WORD_W-1:0]  word_d;
	logic signed [WORD_W-1:0]  word_q;

	assign pos_x = CW'(pos);

	always_comb begin
		word_d = word_q;
		case (ctrl.cmd)
			CMD_INSERT: begin
				if (IDX_C == pos_x) begin
					word_d = ctrl.word;
				end else if ((IDX_C > pos_x) && (IDX_C <= count)) begin
					word_d = prev_word;
				end
			end
			CMD_REMOVE: begin
				// close the gap: every slot from the removed one up to the next-to-last entry takes its upper neighbor
				if ((IDX_C >= pos_x) && (IDX1_C < count)) begin
					word_d = next_word;
				end
			end
			CMD_WRITE: begin
				if (IDX_C == pos_x) begin
					word_d = ctrl.word;
				end
			end
			CMD_ROTATE: word_d = next_word;
			default:    word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

// ===== rtl/shifting_indexed_array_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_indexed_array_core
// Ordered store of up to CAPACITY signed words with insert, remove, search,
// read and write at a position.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY cells, each holding one word and wired to its
// two neighbors. Insert, remove, write and every rejected request finish in
// the cycle of the transfer; their result passes through the result register
// and then the output register to rsp, and the next request is taken only once
// that result has left the result register, since req.ready stays low while the
// result register holds an item not yet moved to rsp.
// Search and read rotate the whole row once past cell 0, the single inspection
// point, and the block takes no new request until that rotation is done and its
// result has left the result register. A result register and an output
// register let the next request be taken while an earlier result still waits
// on rsp; with both full, req.ready stays low.
// No clearing pass after reset: the entry count starts at zero and slots at
// or above it are never read.
// ----------------------------------------------------------------------------
`include "shifting_indexed_array_core_assert.svh"

module shifting_indexed_array_core #(
	parameter int CAPACITY = sia_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sia_req_if.sink    req,
	sia_rsp_if.source  rsp
);
	import sia_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

	// Control state
	ctrl_state_t          state_q, state_d;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        step_q;
	logic                 pend_valid_q;
	logic                 out_valid_q;

	// Sweep context and result payload
	logic [OP_W-1:0]          op_q;
	logic [IW-1:0]            pos_q;
	logic signed [WORD_W-1:0] key_q;
	logic                     hit_q;
	logic [IW-1:0]            hit_pos_q;
	logic signed [WORD_W-1:0] rd_q;
	rsp_t                     pend_q;
	rsp_t                     out_q;

	// Request decode
	logic             acc;
	logic [CMPW-1:0]  pos_c;
	logic [CMPW-1:0]  cnt_c;
	logic             full;
	cell_cmd_t        dec_cmd;
	logic [CW-1:0]    cnt_next;
	logic             start_sweep;
	logic [STATUS_W-1:0] dec_status;

	// Sweep datapath
	logic                     sweeping;
	logic                     last_step;
	logic                     in_use;
	logic                     hit_now;
	logic                     hit_d;
	logic [IW-1:0]            hit_pos_d;
	logic signed [WORD_W-1:0] rd_d;

	// Cell row
	cell_ctrl_t               cell_ctrl;
	logic [IW-1:0]            cell_pos;
	logic signed [WORD_W-1:0] cell_word [CAPACITY];

	// Result handoff
	logic  pend_load;
	rsp_t  pend_d;
	logic  move;

	assign acc      = req.valid && req.ready;
	assign req.ready = (state_q == CS_IDLE) && !pend_valid_q;

	assign pos_c = CMPW'(req.position);
	assign cnt_c = CMPW'(count_q);
	assign full  = (count_q == CW'(CAPACITY));

	always_comb begin
		dec_cmd     = CMD_HOLD;
		dec_status  = STAT_OK;
		cnt_next    = count_q;
		start_sweep = 1'b0;
		case (req.operation)
			OP_INSERT: begin
				if (pos_c > cnt_c) begin
					dec_status = STAT_RANGE;
				end else if (full) begin
					dec_status = STAT_FULL;
				end else begin
					dec_cmd  = CMD_INSERT;
					cnt_next = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos_c >= cnt_c) begin
					dec_status = STAT_RANGE;
				end else begin
					dec_cmd  = CMD_REMOVE;
					cnt_next = count_q - 1'b1;
				end
			end
			OP_SEARCH: start_sweep = 1'b1;
			OP_READ: begin
				if (pos_c >= cnt_c) begin
					dec_status = STAT_RANGE;
				end else begin
					start_sweep = 1'b1;
				end
			end
			OP_WRITE: begin
				if (pos_c >= cnt_c) begin
					dec_status = STAT_RANGE;
				end else begin
					dec_cmd = CMD_WRITE;
				end
			end
			default: dec_status = STAT_RANGE;
		endcase
	end

	// Drive the row: rotate during a sweep, apply the decoded edit on a transfer
	always_comb begin
		cell_ctrl.word = req.data_word;
		if (state_q == CS_SWEEP) begin
			cell_ctrl.cmd = CMD_ROTATE;
		end else if (acc) begin
			cell_ctrl.cmd = dec_cmd;
		end else begin
			cell_ctrl.cmd = CMD_HOLD;
		end
	end

	assign cell_pos = IW'(req.position);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam int PREV = (g == 0) ? 0 : g - 1;
		localparam int NEXT = (g == CAPACITY - 1) ? 0 : g + 1;
		sia_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (g)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.pos       (cell_pos),
			.count     (count_q),
			.prev_word (cell_word[PREV]),
			.next_word (cell_word[NEXT]),
			.word      (cell_word[g])
		);
	end

	// Cell 0 holds entry step_q during the sweep
	assign sweeping  = (state_q == CS_SWEEP);
	assign last_step = (step_q == LAST_STEP);
	assign in_use    = (CW'(step_q) < count_q);
	assign hit_now   = (op_q == OP_SEARCH) && !hit_q && in_use && (cell_word[0] == key_q);
	assign hit_d     = hit_q || hit_now;
	assign hit_pos_d = hit_now ? step_q : hit_pos_q;
	assign rd_d      = ((op_q == OP_READ) && (step_q == pos_q)) ? cell_word[0] : rd_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE:  if (acc && start_sweep) state_d = CS_SWEEP;
			CS_SWEEP: if (last_step) state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		pend_load = 1'b0;
		pend_d    = '0;
		if (sweeping) begin
			pend_load             = last_step;
			pend_d.status         = STAT_OK;
			pend_d.found          = hit_d;
			pend_d.found_position = FPOS_W'(hit_pos_d);
			pend_d.read_word      = rd_d;
			pend_d.entry_count    = ECNT_W'(count_q);
		end else begin
			pend_load          = acc && !start_sweep;
			pend_d.status      = dec_status;
			pend_d.entry_count = ECNT_W'(cnt_next);
		end
	end

	assign move = pend_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CS_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				count_q <= cnt_next;
			end
			if (sweeping) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q      <= req.operation;
			pos_q     <= cell_pos;
			key_q     <= req.data_word;
			hit_q     <= 1'b0;
			hit_pos_q <= '0;
			rd_q      <= '0;
		end else if (sweeping) begin
			hit_q     <= hit_d;
			hit_pos_q <= hit_pos_d;
			rd_q      <= rd_d;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (move) begin
			out_q <= pend_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.found          = out_q.found;
	assign rsp.found_position = out_q.found_position;
	assign rsp.read_word      = out_q.read_word;
	assign rsp.entry_count    = out_q.entry_count;

	`SIA_ASSERT_SAME(a_count_cap, 1'b1, count_q <= CW'(CAPACITY),
		"entry count above capacity")
	`SIA_ASSERT_NEXT(a_insert_count, acc && (dec_cmd == CMD_INSERT),
		count_q == $past(count_q) + 1'b1, "insert did not grow count")
	`SIA_ASSERT_NEXT(a_sweep_count, sweeping, $stable(count_q), "count moved during sweep")
	`SIA_ASSERT_NEXT(a_pend_hold, pend_valid_q && !move, pend_valid_q, "pending result lost")
	`SIA_ASSERT_SAME(a_found_ok, rsp.valid && rsp.found, rsp.status == STAT_OK,
		"hit with error status")

endmodule
